FILE: hw/rtl/cscr_pkg.sv
// Shared constants for the clock second-chance replacer.
// No dependencies; used by the top level and the lookup/sweep engine.
package cscr_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int PAGE_BITS_DEF = 20;
  localparam int CFG_W         = 7;
  localparam int SLOT_IDX_W    = 6;

  localparam logic [CFG_W-1:0] CFG_NUM_SLOTS_RST = 7'd64;

endpackage

FILE: hw/rtl/cscr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents when it hits the address written in the same cycle.
// No dependencies.
module cscr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/cscr_engine.sv
// Lookup and clock-sweep sequencer with the result register.
// Drives the slot RAM (cscr_ram) through read-modify-write; uses cscr_pkg constants.
module cscr_engine #(
  parameter int MAX_SLOTS = cscr_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = cscr_pkg::PAGE_BITS_DEF,
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int CNT_W = $clog2(MAX_SLOTS + 1),
  localparam int ENT_W = PAGE_BITS + 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [CNT_W-1:0]                n_active,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PAGE_BITS-1:0]            in_page_number,
  input  logic                            in_is_write,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [cscr_pkg::SLOT_IDX_W-1:0] out_slot_index,
  output logic                            out_evicted_valid,
  output logic [PAGE_BITS-1:0]            out_evicted_page,
  output logic                            ram_wr_en,
  output logic [IDX_W-1:0]                ram_wr_addr,
  output logic [ENT_W-1:0]                ram_wr_data,
  output logic [IDX_W-1:0]                ram_rd_addr,
  input  logic [ENT_W-1:0]                ram_rd_data
);

  localparam int STEP_W = CNT_W + 2;
  localparam int SX_W = (IDX_W > cscr_pkg::SLOT_IDX_W) ? IDX_W : cscr_pkg::SLOT_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP
  } state_t;

  state_t              state_r, state_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                wr_r, wr_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    h_r, h_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic [STEP_W-1:0]   limit_r, limit_nxt;
  logic [IDX_W-1:0]    hand_r, hand_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic                fwd_r, fwd_nxt;
  logic [ENT_W-1:0]    fwd_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [IDX_W-1:0]    out_slot_r, out_slot_nxt;
  logic                out_ev_valid_r, out_ev_valid_nxt;
  logic [PAGE_BITS-1:0] out_ev_page_r, out_ev_page_nxt;

  logic [ENT_W-1:0]    ent;
  logic                ent_ref, ent_dirty;
  logic [PAGE_BITS-1:0] ent_tag;
  logic                out_free;
  logic [CNT_W-1:0]    idx_inc, h_inc, lim_accept;
  logic [IDX_W-1:0]    h_next, hand_start;
  logic                look_hit, look_last, fill_ok, sweep_take;
  logic [SX_W-1:0]     slot_ext;

  assign ent        = fwd_r ? fwd_data_r : ram_rd_data;
  assign ent_ref    = ent[PAGE_BITS+1];
  assign ent_dirty  = ent[PAGE_BITS];
  assign ent_tag    = ent[PAGE_BITS-1:0];
  assign out_free   = !out_valid_r || !out_stall;
  assign idx_inc    = idx_r + CNT_W'(1);
  assign h_inc      = CNT_W'(h_r) + CNT_W'(1);
  assign h_next     = (h_inc >= n_r) ? '0 : h_inc[IDX_W-1:0];
  assign hand_start = (CNT_W'(hand_r) >= n_r) ? '0 : hand_r;
  assign lim_accept = (fill_r < n_active) ? fill_r : n_active;
  assign look_hit   = (lim_r != '0) && (ent_tag == page_r);
  assign look_last  = (lim_r == '0) || (idx_inc >= lim_r);
  assign fill_ok    = fill_r < n_r;
  assign sweep_take = (!ent_ref && !ent_dirty) || (steps_r == limit_r);
  assign in_stall   = state_r != ST_IDLE;

  always_comb begin
    state_nxt        = state_r;
    page_nxt         = page_r;
    wr_nxt           = wr_r;
    n_nxt            = n_r;
    lim_nxt          = lim_r;
    idx_nxt          = idx_r;
    h_nxt            = h_r;
    steps_nxt        = steps_r;
    limit_nxt        = limit_r;
    hand_nxt         = hand_r;
    fill_nxt         = fill_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_hit_nxt      = out_hit_r;
    out_slot_nxt     = out_slot_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = '0;
    ram_wr_data      = '0;
    ram_rd_addr      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_page_number;
          wr_nxt    = in_is_write;
          n_nxt     = n_active;
          lim_nxt   = lim_accept;
          idx_nxt   = '0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (look_hit) begin
          ram_rd_addr = idx_r[IDX_W-1:0];
          if (out_free) begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = idx_r[IDX_W-1:0];
            ram_wr_data      = {1'b1, ent_dirty | wr_r, page_r};
            out_valid_nxt    = 1'b1;
            out_hit_nxt      = 1'b1;
            out_slot_nxt     = idx_r[IDX_W-1:0];
            out_ev_valid_nxt = 1'b0;
            out_ev_page_nxt  = '0;
            state_nxt        = ST_IDLE;
          end
        end else if (look_last) begin
          if (fill_ok) begin
            ram_rd_addr = idx_r[IDX_W-1:0];
            if (out_free) begin
              ram_wr_en        = 1'b1;
              ram_wr_addr      = fill_r[IDX_W-1:0];
              ram_wr_data      = {1'b1, wr_r, page_r};
              fill_nxt         = fill_r + CNT_W'(1);
              out_valid_nxt    = 1'b1;
              out_hit_nxt      = 1'b0;
              out_slot_nxt     = fill_r[IDX_W-1:0];
              out_ev_valid_nxt = 1'b0;
              out_ev_page_nxt  = '0;
              state_nxt        = ST_IDLE;
            end
          end else begin
            ram_rd_addr = hand_start;
            h_nxt       = hand_start;
            steps_nxt   = '0;
            limit_nxt   = (STEP_W'(n_r) << 1) + STEP_W'(n_r) + STEP_W'(1);
            state_nxt   = ST_SWEEP;
          end
        end else begin
          idx_nxt     = idx_inc;
          ram_rd_addr = idx_inc[IDX_W-1:0];
        end
      end
      ST_SWEEP: begin
        if (sweep_take) begin
          ram_rd_addr = h_r;
          if (out_free) begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = h_r;
            ram_wr_data      = {1'b1, wr_r, page_r};
            hand_nxt         = h_next;
            out_valid_nxt    = 1'b1;
            out_hit_nxt      = 1'b0;
            out_slot_nxt     = h_r;
            out_ev_valid_nxt = 1'b1;
            out_ev_page_nxt  = ent_tag;
            state_nxt        = ST_IDLE;
          end
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = h_r;
          ram_wr_data = {1'b0, ent_ref & ent_dirty, ent_tag};
          h_nxt       = h_next;
          steps_nxt   = steps_r + STEP_W'(1);
          ram_rd_addr = h_next;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    fwd_nxt = ram_wr_en && (ram_wr_addr == ram_rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hand_r      <= '0;
      fill_r      <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hand_r      <= hand_nxt;
      fill_r      <= fill_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r         <= page_nxt;
    wr_r           <= wr_nxt;
    n_r            <= n_nxt;
    lim_r          <= lim_nxt;
    idx_r          <= idx_nxt;
    h_r            <= h_nxt;
    steps_r        <= steps_nxt;
    limit_r        <= limit_nxt;
    fwd_data_r     <= ram_wr_data;
    out_hit_r      <= out_hit_nxt;
    out_slot_r     <= out_slot_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
  end

  assign slot_ext          = SX_W'(out_slot_r);
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot_index    = slot_ext[cscr_pkg::SLOT_IDX_W-1:0];
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

endmodule

FILE: hw/rtl/clock_second_chance_replacer.sv
// Top level of the clock second-chance replacer: slot-count register and clamp.
// Instantiates cscr_engine and cscr_ram; constants from cscr_pkg.
//
// Usage: each input transaction (in_page_number, in_is_write) is looked up in a
// fully associative table of page slots; exactly one result transaction follows,
// giving hit, the slot now holding the page, and the page evicted, if any.
// Slot state (tag, reference and dirty bits) lives in one RAM, read one slot
// per cycle while the lookup or the sweep advances. Validity follows from the
// fill count, so no clearing pass is needed. A hit in slot j ends the scan at
// slot j. A miss scans all filled active slots (L of them) and takes a free
// slot when one remains; once the table is full the hand sweep clears the
// reference bit of each slot it passes until it finds one clear of both bits
// or reaches its step limit, and evicts that slot.
// Throughput is one transaction at a time, set by the single RAM read port: the
// next input is accepted in the cycle after the result register loads.
// Reset empties the table, parks the hand at slot 0 and sets the slot count to
// 64. While the receiver stalls, the result is held; the next transaction is
// still accepted and processed up to its result, which waits for the register.
// The user must write cfg_num_slots only when the block is idle; the block does not enforce this.
module clock_second_chance_replacer #(
  parameter int MAX_SLOTS = cscr_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = cscr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cscr_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PAGE_BITS-1:0]            in_page_number,
  input  logic                            in_is_write,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [cscr_pkg::SLOT_IDX_W-1:0] out_slot_index,
  output logic                            out_evicted_valid,
  output logic [PAGE_BITS-1:0]            out_evicted_page
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int ENT_W = PAGE_BITS + 2;
  localparam int CW    = (CNT_W > cscr_pkg::CFG_W) ? CNT_W : cscr_pkg::CFG_W;

  logic [cscr_pkg::CFG_W-1:0] cfg_num_slots_r;
  logic [CW-1:0]              cfg_ext;
  logic [CNT_W-1:0]           n_active;
  logic                       ram_wr_en;
  logic [IDX_W-1:0]           ram_wr_addr;
  logic [ENT_W-1:0]           ram_wr_data;
  logic [IDX_W-1:0]           ram_rd_addr;
  logic [ENT_W-1:0]           ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_slots_r <= cscr_pkg::CFG_NUM_SLOTS_RST;
    end else if (cfg_wr_en) begin
      cfg_num_slots_r <= cfg_wr_data;
    end
  end

  assign cfg_ext  = CW'(cfg_num_slots_r);
  assign n_active = (cfg_ext == '0) ? CNT_W'(1) :
                    (cfg_ext > CW'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg_ext[CNT_W-1:0];

  cscr_engine #(
    .MAX_SLOTS(MAX_SLOTS),
    .PAGE_BITS(PAGE_BITS)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .n_active         (n_active),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_number   (in_page_number),
    .in_is_write      (in_is_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_slot_index   (out_slot_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data)
  );

  cscr_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule
